@@ hdl/wmra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmra_pkg
// shared widths, register indexes and stage types of the windowed magnitude
// running average block
// ----------------------------------------------------------------------------
package wmra_pkg;

   localparam int STORE_DEPTH   = 65536;
   localparam int SAMPLE_BITS   = 24;
   localparam int POS_BITS      = $clog2(STORE_DEPTH);
   localparam int LAG_BITS      = 20;
   localparam int LEN_BITS      = 17;
   localparam int FRAMES_BITS   = 32;
   localparam int AVG_BITS      = 24;
   localparam int SQ_BITS       = 2 * SAMPLE_BITS;
   localparam int ROOT_BITS     = SAMPLE_BITS;
   localparam int PROD_BITS     = AVG_BITS + FRAMES_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   // two root or quotient bits are resolved per register stage
   localparam int STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;
   localparam int DIV_STAGES      = AVG_BITS / STEPS_PER_STAGE;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_START  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LENGTH = 2'd1;

   typedef struct packed {
      logic                   vld;
      logic [POS_BITS-1:0]    pos;
   } occ_type;

   typedef struct packed {
      logic [POS_BITS-1:0]    pos;
      logic [FRAMES_BITS-1:0] frames;
      logic [PROD_BITS-1:0]   prod;
   } sqrt_side_type;

endpackage

@@ hdl/wmra_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmra channel interfaces
// valid/ready channels for lag bins in and averages out
// ----------------------------------------------------------------------------
interface wmra_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [wmra_pkg::SAMPLE_BITS-1:0]  sample_re;
   logic signed [wmra_pkg::SAMPLE_BITS-1:0]  sample_im;
   logic [wmra_pkg::LAG_BITS-1:0]            lag_index;
   logic [wmra_pkg::FRAMES_BITS-1:0]         frames_seen;

   modport source (output valid, sample_re, sample_im, lag_index, frames_seen,
                   input ready);
   modport sink (input valid, sample_re, sample_im, lag_index, frames_seen,
                 output ready);
endinterface

interface wmra_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wmra_pkg::POS_BITS-1:0]   position;
   logic [wmra_pkg::AVG_BITS-1:0]   average;

   modport source (output valid, position, average, input ready);
   modport sink (input valid, position, average, output ready);
endinterface

@@ hdl/wmra_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmra_sqrt_pipe
// pipelined floor square root, two root bits per stage, sideband carried along
// ----------------------------------------------------------------------------
module wmra_sqrt_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [wmra_pkg::SQ_BITS-1:0]   in_rad,
   input  wmra_pkg::sqrt_side_type    in_side,
   output logic                       out_vld,
   output logic [wmra_pkg::ROOT_BITS-1:0] out_root,
   output wmra_pkg::sqrt_side_type    out_side,
   output wmra_pkg::occ_type [wmra_pkg::SQRT_STAGES-1:0] occ
);
   import wmra_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int LAST     = SQRT_STAGES - 1;

   logic [SQRT_STAGES-1:0] vld_ff;
   logic [SQ_BITS-1:0]     rad_ff  [SQRT_STAGES];
   logic [REM_BITS-1:0]    rem_ff  [SQRT_STAGES];
   logic [ROOT_BITS-1:0]   root_ff [SQRT_STAGES];
   sqrt_side_type          side_ff [SQRT_STAGES];

   logic [SQ_BITS-1:0]     rad_in  [SQRT_STAGES];
   logic [REM_BITS-1:0]    rem_in  [SQRT_STAGES];
   logic [ROOT_BITS-1:0]   root_in [SQRT_STAGES];

   // stage sources: index 0 is the pipe input
   logic [SQ_BITS-1:0]     rad_src  [SQRT_STAGES+1];
   logic [REM_BITS-1:0]    rem_src  [SQRT_STAGES+1];
   logic [ROOT_BITS-1:0]   root_src [SQRT_STAGES+1];

   always_comb begin
      rad_src[0]  = in_rad;
      rem_src[0]  = '0;
      root_src[0] = '0;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         rad_src[k+1]  = rad_ff[k];
         rem_src[k+1]  = rem_ff[k];
         root_src[k+1] = root_ff[k];
      end
   end

   always_comb begin
      logic [SQ_BITS-1:0]    rad;
      logic [REM_BITS-1:0]   rem;
      logic [ROOT_BITS-1:0]  root;
      logic [REM_BITS+1:0]   part;
      logic [REM_BITS+1:0]   trial;
      logic                  bit_set;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         rad  = rad_src[k];
         rem  = rem_src[k];
         root = root_src[k];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            part    = {rem, rad[SQ_BITS-1 -: 2]};
            trial   = {2'b00, root, 2'b01};
            bit_set = (part >= trial);
            if (bit_set) begin
               part = part - trial;
            end
            rem  = part[REM_BITS-1:0];
            root = {root[ROOT_BITS-2:0], bit_set};
            rad  = {rad[SQ_BITS-3:0], 2'b00};
         end
         rad_in[k]  = rad;
         rem_in[k]  = rem;
         root_in[k] = root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQRT_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         side_ff[0] <= in_side;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         occ[k].vld = vld_ff[k];
         occ[k].pos = side_ff[k].pos;
      end
   end

   assign out_vld  = vld_ff[LAST];
   assign out_root = root_ff[LAST];
   assign out_side = side_ff[LAST];

   // remainder of a finished root never exceeds twice the root
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> ({1'b0, rem_ff[LAST]} <= {2'b00, root_ff[LAST], 1'b0}))
      else $error("sqrt remainder out of bound");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("sqrt pipe moved while stalled");

   a_entry : assert property (@(posedge clock) disable iff (reset)
      en && !reset |=> vld_ff[0] == $past(in_vld))
      else $error("sqrt pipe lost an entering word");

endmodule

@@ hdl/wmra_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmra_div_pipe
// pipelined restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module wmra_div_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic [wmra_pkg::PROD_BITS-1:0]  in_num,
   input  logic [wmra_pkg::FRAMES_BITS-1:0] in_den,
   input  logic [wmra_pkg::POS_BITS-1:0]   in_pos,
   output logic                            out_vld,
   output logic [wmra_pkg::AVG_BITS-1:0]   out_quo,
   output logic [wmra_pkg::POS_BITS-1:0]   out_pos,
   output wmra_pkg::occ_type [wmra_pkg::DIV_STAGES-1:0] occ
);
   import wmra_pkg::*;

   localparam int REM_BITS = FRAMES_BITS;
   localparam int LAST     = DIV_STAGES - 1;

   logic [DIV_STAGES-1:0] vld_ff;
   logic [REM_BITS-1:0]   rem_ff [DIV_STAGES];
   logic [AVG_BITS-1:0]   low_ff [DIV_STAGES];
   logic [REM_BITS-1:0]   den_ff [DIV_STAGES];
   logic [POS_BITS-1:0]   pos_ff [DIV_STAGES];

   logic [REM_BITS-1:0]   rem_in [DIV_STAGES];
   logic [AVG_BITS-1:0]   low_in [DIV_STAGES];

   logic [REM_BITS-1:0]   rem_src [DIV_STAGES+1];
   logic [AVG_BITS-1:0]   low_src [DIV_STAGES+1];
   logic [REM_BITS-1:0]   den_src [DIV_STAGES+1];

   always_comb begin
      rem_src[0] = in_num[PROD_BITS-1:AVG_BITS];
      low_src[0] = in_num[AVG_BITS-1:0];
      den_src[0] = in_den;
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_src[k+1] = rem_ff[k];
         low_src[k+1] = low_ff[k];
         den_src[k+1] = den_ff[k];
      end
   end

   always_comb begin
      logic [REM_BITS-1:0] rem;
      logic [AVG_BITS-1:0] low;
      logic [REM_BITS:0]   part;
      logic                q_bit;
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem = rem_src[k];
         low = low_src[k];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            part  = {rem, low[AVG_BITS-1]};
            q_bit = (part >= {1'b0, den_src[k]});
            if (q_bit) begin
               part = part - {1'b0, den_src[k]};
            end
            rem = part[REM_BITS-1:0];
            low = {low[AVG_BITS-2:0], q_bit};
         end
         rem_in[k] = rem;
         low_in[k] = low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_src[k];
         end
         pos_ff[0] <= in_pos;
         for (int k = 1; k < DIV_STAGES; k++) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         occ[k].vld = vld_ff[k];
         occ[k].pos = pos_ff[k];
      end
   end

   assign out_vld = vld_ff[LAST];
   assign out_quo = low_ff[LAST];
   assign out_pos = pos_ff[LAST];

   // partial remainder stays below the divisor in every live stage; the first and last are checked
   a_rem_first : assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> rem_ff[0] < den_ff[0])
      else $error("divider overflow at first stage");

   a_rem_last : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> rem_ff[LAST] < den_ff[LAST])
      else $error("divider remainder out of bound");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("divider moved while stalled");

endmodule

@@ hdl/windowed_magnitude_running_average_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_magnitude_running_average_top
// running average of complex bin magnitude per window position
// ----------------------------------------------------------------------------
// req_chan carries one complex lag bin per word with its lag and frame count.
// bins whose lag lies in [window_start, window_start + window_length) (window
// cut to the store depth) are processed, other words are taken and dropped.
// rsp_chan carries the window position and the updated average.
// csr_wr_en / csr_index / csr_wr_data write window_start (index 0) and
// window_length (index 1); write only while the block is idle.
// throughput: one word per cycle when not stalled or held; a bin whose position
// is still in flight is held at req_chan until the earlier word writes its
// average back, since the average feeds on the previous one at that position.
// most of the pipe depth comes from the 12-stage root and 12-stage divider.
// reset: a clearing pass writes zero to all 65536 store entries, one per
// cycle; req_chan.ready stays low until the pass is over.
// a stalled rsp_chan freezes the whole pipe; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module windowed_magnitude_running_average_top (
   input  logic                                clock,
   input  logic                                reset,
   wmra_req_if.sink                            req_chan,
   wmra_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [wmra_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wmra_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import wmra_pkg::*;

   // window registers
   logic [LAG_BITS-1:0] start_ff;
   logic [LEN_BITS-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_START:  start_ff <= csr_wr_data[LAG_BITS-1:0];
            CSR_WINDOW_LENGTH: len_ff   <= LEN_BITS'(csr_wr_data);
            default: ;
         endcase
      end
   end

   // clearing pass after reset
   logic                clr_busy_ff;
   logic [POS_BITS-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == POS_BITS'(STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // pipeline advance: the whole pipe moves unless the output word is stuck
   logic rsp_vld_ff;
   logic adv;
   assign adv = !rsp_vld_ff || rsp_chan.ready;

   // window check on the incoming word
   logic [LAG_BITS-1:0] lag_off;
   logic [LEN_BITS-1:0] len_eff;
   logic                in_win;
   logic [POS_BITS-1:0] req_pos;

   assign lag_off = req_chan.lag_index - start_ff;
   assign len_eff = (len_ff > LEN_BITS'(STORE_DEPTH)) ? LEN_BITS'(STORE_DEPTH) : len_ff;
   assign in_win  = (req_chan.lag_index >= start_ff) && (lag_off < LAG_BITS'(len_eff));
   assign req_pos = lag_off[POS_BITS-1:0];

   // stage registers ahead of the root
   logic                   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [SAMPLE_BITS-1:0] s1_re_ff, s1_im_ff;
   logic [POS_BITS-1:0]    s1_pos_ff, s2_pos_ff, s3_pos_ff, s4_pos_ff;
   logic [FRAMES_BITS-1:0] s1_frm_ff, s2_frm_ff, s3_frm_ff, s4_frm_ff;
   logic [SQ_BITS-1:0]     s2_sqre_ff, s2_sqim_ff, s3_sum_ff, s4_sum_ff;
   logic [AVG_BITS-1:0]    rd_ff;
   logic [PROD_BITS-1:0]   s4_prod_ff;
   logic [FRAMES_BITS-1:0] frm_m1;

   // after the root, before the divider
   logic                   d0_vld_ff;
   logic [PROD_BITS-1:0]   d0_num_ff;
   logic [FRAMES_BITS-1:0] d0_den_ff;
   logic [POS_BITS-1:0]    d0_pos_ff;

   // sub-unit wiring
   sqrt_side_type          sq_side_in, sq_side_out;
   logic                   sq_out_vld;
   logic [ROOT_BITS-1:0]   sq_root;
   occ_type [SQRT_STAGES-1:0] sq_occ;
   logic                   dv_out_vld;
   logic [AVG_BITS-1:0]    dv_quo;
   logic [POS_BITS-1:0]    dv_pos;
   occ_type [DIV_STAGES-1:0]  dv_occ;

   // a bin may not enter while its position still waits for write-back
   logic hit;
   logic hazard;

   always_comb begin
      hit = (s1_vld_ff && s1_pos_ff == req_pos) || (s2_vld_ff && s2_pos_ff == req_pos)
         || (s3_vld_ff && s3_pos_ff == req_pos) || (s4_vld_ff && s4_pos_ff == req_pos)
         || (d0_vld_ff && d0_pos_ff == req_pos);
      for (int k = 0; k < SQRT_STAGES; k++) begin
         hit = hit || (sq_occ[k].vld && sq_occ[k].pos == req_pos);
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         hit = hit || (dv_occ[k].vld && dv_occ[k].pos == req_pos);
      end
   end

   assign hazard         = in_win && hit;
   assign req_chan.ready = adv && !clr_busy_ff && !hazard;

   logic accept;
   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         d0_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= accept && in_win;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         d0_vld_ff <= sq_out_vld;
      end
   end

   assign frm_m1 = s3_frm_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (adv) begin
         // magnitudes of the parts; the most negative value maps to 2^23
         s1_re_ff   <= req_chan.sample_re[SAMPLE_BITS-1]
                       ? (~req_chan.sample_re + 1'b1) : req_chan.sample_re;
         s1_im_ff   <= req_chan.sample_im[SAMPLE_BITS-1]
                       ? (~req_chan.sample_im + 1'b1) : req_chan.sample_im;
         s1_pos_ff  <= req_pos;
         s1_frm_ff  <= req_chan.frames_seen;
         // squares
         s2_sqre_ff <= SQ_BITS'(s1_re_ff) * SQ_BITS'(s1_re_ff);
         s2_sqim_ff <= SQ_BITS'(s1_im_ff) * SQ_BITS'(s1_im_ff);
         s2_pos_ff  <= s1_pos_ff;
         s2_frm_ff  <= s1_frm_ff;
         // sum of squares; previous average is read alongside
         s3_sum_ff  <= s2_sqre_ff + s2_sqim_ff;
         s3_pos_ff  <= s2_pos_ff;
         s3_frm_ff  <= s2_frm_ff;
         // previous average weighted by count minus one
         s4_prod_ff <= PROD_BITS'(rd_ff) * PROD_BITS'(frm_m1);
         s4_sum_ff  <= s3_sum_ff;
         s4_pos_ff  <= s3_pos_ff;
         s4_frm_ff  <= s3_frm_ff;
         // first frame passes the magnitude through a divide by one
         if (sq_side_out.frames == '0) begin
            d0_num_ff <= PROD_BITS'(sq_root);
            d0_den_ff <= FRAMES_BITS'(1);
         end else begin
            d0_num_ff <= sq_side_out.prod + PROD_BITS'(sq_root);
            d0_den_ff <= sq_side_out.frames;
         end
         d0_pos_ff <= sq_side_out.pos;
      end
   end

   assign sq_side_in.pos    = s4_pos_ff;
   assign sq_side_in.frames = s4_frm_ff;
   assign sq_side_in.prod   = s4_prod_ff;

   wmra_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s4_vld_ff),
      .in_rad   (s4_sum_ff),
      .in_side  (sq_side_in),
      .out_vld  (sq_out_vld),
      .out_root (sq_root),
      .out_side (sq_side_out),
      .occ      (sq_occ)
   );

   wmra_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (d0_vld_ff),
      .in_num  (d0_num_ff),
      .in_den  (d0_den_ff),
      .in_pos  (d0_pos_ff),
      .out_vld (dv_out_vld),
      .out_quo (dv_quo),
      .out_pos (dv_pos),
      .occ     (dv_occ)
   );

   // average store: one write and one registered read per cycle
   logic [AVG_BITS-1:0] store_mem [STORE_DEPTH];
   logic                st_we;
   logic [POS_BITS-1:0] st_addr;
   logic [AVG_BITS-1:0] st_data;

   assign st_we   = clr_busy_ff || (adv && dv_out_vld);
   assign st_addr = clr_busy_ff ? clr_cnt_ff : dv_pos;
   assign st_data = clr_busy_ff ? '0 : dv_quo;

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_addr] <= st_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= store_mem[s2_pos_ff];
      end
   end

   // output register
   logic [POS_BITS-1:0] rsp_pos_ff;
   logic [AVG_BITS-1:0] rsp_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_out_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && dv_out_vld) begin
         rsp_pos_ff <= dv_pos;
         rsp_avg_ff <= dv_quo;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.position = rsp_pos_ff;
   assign rsp_chan.average  = rsp_avg_ff;

   a_no_accept_clear : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_chan.ready)
      else $error("word accepted during clearing pass");

   a_wb_to_out : assert property (@(posedge clock) disable iff (reset)
      (st_we && !clr_busy_ff) |=> rsp_vld_ff && rsp_pos_ff == $past(dv_pos))
      else $error("store write-back without matching output word");

   a_clear_len : assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_cnt_ff) == POS_BITS'(STORE_DEPTH - 1))
      else $error("clearing pass ended early");

endmodule
